### rtl/pw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pw_pkg: shared types and constants for the two-level page walker
// field widths, beat widths, result codes and the queue entry format
// ----------------------------------------------------------------------------
package pw_pkg;

    // address split
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned VLOW_W     = OFFSET_W + IDX_W;
    localparam int unsigned PAGE_BYTES = 4096;

    // beat widths
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 72;

    // queue between front and back
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QADDR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // input kinds (s_axis_tuser)
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_READ_DATA = 1'b1;

    // output kinds (m_axis_tuser)
    localparam logic OUT_READ   = 1'b0;
    localparam logic OUT_RESULT = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CROSS       = 2'd2;

    // present bit position in an entry
    localparam int unsigned PRESENT_BIT = 0;

    // classified item handed from front to back
    typedef struct packed {
        logic                is_read_data; // returning entry word
        logic [ADDR_W-1:0]   word;         // directory read address or entry word
        logic [VLOW_W-1:0]   vlow;         // table index and offset
        logic [LEN_W-1:0]    len;          // access length
    } q_entry_t;

    // queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // clear the offset bits of a word
    function automatic logic [ADDR_W-1:0] frame_of(input logic [ADDR_W-1:0] w);
        frame_of = {w[ADDR_W-1:OFFSET_W], {OFFSET_W{1'b0}}};
    endfunction

endpackage

### rtl/two_level_page_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_walker_top: two-level page table walker
// issues directory and table entry reads and returns translated addresses
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  s_axis   | in        | translate request or returning entry word
//  m_axis   | out       | entry read request or translation result
//  cfg      | in        | page directory base (low 12 bits ignored)
//
//  one input beat is taken per cycle while the queue has room; its output
//  beat, if any, is queued and then registered by the walk sequencer.
//  a four-entry queue sits between front and back; while a result waits on
//  m_axis_tready up to four new beats queue up, then s_axis_tready drops.
//  rst_n clears the base register, the walk phase, the queue and the output
//  valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_level_page_walker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pw_pkg::ADDR_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // virt_addr[31:0], access_len[35:32], read_data[67:36], zero fill
    input  logic [pw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                          s_axis_tuser,
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // mem_addr[31:0], status[33:32], phys_addr[65:34], zero fill
    output logic [pw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // out_kind
    output logic                          m_axis_tuser
);
    import pw_pkg::*;

    q_entry_t   front_entry;
    q_entry_t   head;
    q_status_t  q_status;
    logic       push;
    logic       pop;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && !q_status.full;

    // classification
    pw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .in_tdata (s_axis_tdata),
        .in_tuser (s_axis_tuser),
        .entry    (front_entry)
    );

    // decoupling queue
    pw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(front_entry),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // walk sequencer
    pw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_tvalid(m_axis_tvalid),
        .out_tready(m_axis_tready),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

endmodule

### rtl/pw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pw_front: input classification
// holds the directory base, unpacks input beats and forms queue entries;
// a translate request gets its directory entry address computed here
// ----------------------------------------------------------------------------
module pw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [pw_pkg::ADDR_W-1:0]     cfg_data,
    input  logic [pw_pkg::S_TDATA_W-1:0]  in_tdata,
    input  logic                          in_tuser,
    output pw_pkg::q_entry_t              entry
);
    import pw_pkg::*;

    logic [ADDR_W-1:0] dir_base_reg;
    logic [ADDR_W-1:0] virt_addr;
    logic [LEN_W-1:0]  access_len;
    logic [ADDR_W-1:0] read_data;
    logic [ADDR_W-1:0] dir_addr;

    // directory base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            dir_base_reg <= cfg_data;
        end
    end

    // beat unpack
    assign virt_addr  = in_tdata[ADDR_W-1:0];
    assign access_len = in_tdata[ADDR_W+LEN_W-1:ADDR_W];
    assign read_data  = in_tdata[2*ADDR_W+LEN_W-1:ADDR_W+LEN_W];

    // directory entry address, wraps modulo 2^32
    assign dir_addr = frame_of(dir_base_reg)
                    + {{(ADDR_W-IDX_W-2){1'b0}}, virt_addr[ADDR_W-1:VLOW_W], 2'b00};

    // queue entry
    always_comb
    begin
        entry.is_read_data = (in_tuser == KIND_READ_DATA);
        entry.word         = (in_tuser == KIND_READ_DATA) ? read_data : dir_addr;
        entry.vlow         = virt_addr[VLOW_W-1:0];
        entry.len          = access_len;
    end

endmodule

### rtl/pw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pw_queue: short queue between front and back
// small first-in first-out store of classified entries
// ----------------------------------------------------------------------------
module pw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pw_pkg::q_entry_t    push_entry,
    input  logic                pop,
    output pw_pkg::q_entry_t    head,
    output pw_pkg::q_status_t   status
);
    import pw_pkg::*;

    q_entry_t            mem [QDEPTH];
    logic [QADDR_W-1:0]  wr_ptr_reg;
    logic [QADDR_W-1:0]  wr_ptr_next;
    logic [QADDR_W-1:0]  rd_ptr_reg;
    logic [QADDR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### rtl/pw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pw_back: walk sequencer and output register
// tracks the walk phase, turns queue entries into read requests or
// translation results, and holds the outgoing beat until it is taken
// ----------------------------------------------------------------------------
module pw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pw_pkg::q_entry_t              head,
    input  pw_pkg::q_status_t             q_status,
    output logic                          pop,
    output logic                          out_tvalid,
    input  logic                          out_tready,
    output logic [pw_pkg::M_TDATA_W-1:0]  out_tdata,
    output logic                          out_tuser
);
    import pw_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIR,
        PH_TBL
    } phase_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [VLOW_W-1:0]    vlow_reg;
    logic [VLOW_W-1:0]    vlow_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;

    logic                 valid_reg;
    logic                 valid_next;
    logic                 okind_reg;
    logic                 okind_next;
    logic [ADDR_W-1:0]    maddr_reg;
    logic [ADDR_W-1:0]    maddr_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [ADDR_W-1:0]    paddr_reg;
    logic [ADDR_W-1:0]    paddr_next;

    logic                 present;
    logic [ADDR_W-1:0]    tbl_addr;
    logic [OFFSET_W:0]    end_sum;
    logic                 crosses;
    logic                 emit;

    // advance when the queue is not empty and the output slot is free or being drained
    assign pop = !q_status.empty && (!valid_reg || out_tready);

    // entry checks
    assign present  = head.word[PRESENT_BIT];
    assign tbl_addr = frame_of(head.word)
                    + {{(ADDR_W-IDX_W-2){1'b0}}, vlow_reg[VLOW_W-1:OFFSET_W], 2'b00};
    assign end_sum  = {1'b0, vlow_reg[OFFSET_W-1:0]}
                    + {{(OFFSET_W+1-LEN_W){1'b0}}, len_reg};
    assign crosses  = end_sum > (OFFSET_W+1)'(PAGE_BYTES);

    // walk step
    always_comb
    begin
        phase_next  = phase_reg;
        vlow_next   = vlow_reg;
        len_next    = len_reg;
        emit        = 1'b0;
        okind_next  = OUT_READ;
        maddr_next  = '0;
        status_next = ST_OK;
        paddr_next  = '0;
        if (pop)
        begin
            if (!head.is_read_data)
            begin
                // new walk, abandons any walk in flight
                phase_next = PH_DIR;
                vlow_next  = head.vlow;
                len_next   = head.len;
                emit       = 1'b1;
                maddr_next = head.word;
            end
            else
            begin
                case (phase_reg)
                    PH_DIR:
                    begin
                        emit = 1'b1;
                        if (present)
                        begin
                            phase_next = PH_TBL;
                            maddr_next = tbl_addr;
                        end
                        else
                        begin
                            phase_next  = PH_IDLE;
                            okind_next  = OUT_RESULT;
                            status_next = ST_NOT_PRESENT;
                        end
                    end
                    PH_TBL:
                    begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                        okind_next = OUT_RESULT;
                        if (present)
                        begin
                            status_next = crosses ? ST_CROSS : ST_OK;
                            paddr_next  = frame_of(head.word)
                                        | {{(ADDR_W-OFFSET_W){1'b0}},
                                           vlow_reg[OFFSET_W-1:0]};
                        end
                        else
                        begin
                            status_next = ST_NOT_PRESENT;
                        end
                    end
                    default:
                    begin
                        // stray read data while idle is dropped
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        valid_next = emit || (valid_reg && !out_tready);
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            vlow_reg  <= '0;
            len_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            vlow_reg  <= vlow_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            okind_reg  <= okind_next;
            maddr_reg  <= maddr_next;
            status_reg <= status_next;
            paddr_reg  <= paddr_next;
        end
    end

    // beat pack
    assign out_tvalid = valid_reg;
    assign out_tuser  = okind_reg;
    assign out_tdata  = {{(M_TDATA_W-2*ADDR_W-STATUS_W){1'b0}},
                         paddr_reg, status_reg, maddr_reg};

endmodule
